[design/stc_pkg.sv]
package stc_pkg;

    localparam int HEAP_DEPTH = 1024;
    localparam int COORD_BITS = 40;
    localparam int IDX_W      = $clog2(HEAP_DEPTH);
    localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
    localparam int SLOPE_W    = 16;
    localparam int ARG_W      = 40;
    localparam int MIN_W      = 64;

    // highest count at which a hinge add still has two free slots per heap
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(HEAP_DEPTH - 2);

    localparam logic signed [COORD_BITS-1:0] COORD_LO = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic signed [COORD_BITS-1:0] COORD_HI = {1'b0, {(COORD_BITS-1){1'b1}}};

    typedef enum logic [2:0] {
        OP_ADD_CONST  = 3'd0,
        OP_ADD_DEC    = 3'd1,
        OP_ADD_INC    = 3'd2,
        OP_SHIFT      = 3'd3,
        OP_PREFIX_MIN = 3'd4,
        OP_SUFFIX_MIN = 3'd5,
        OP_RANGE_MIN  = 3'd6,
        OP_RESERVED   = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_EXEC,
        S_MUL,
        S_ACC,
        S_PUSH_NEAR,
        S_LOOP,
        S_AFTERPOP,
        S_POST,
        S_PU_CHK,
        S_PU_CMP,
        S_PU_WR,
        S_PO_LAST,
        S_PO_CHK,
        S_PO_K1,
        S_PO_K2,
        S_PO_CMP,
        S_PO_WR,
        S_DONE
    } state_t;

    // one breakpoint: stored coordinate and slope change
    typedef struct packed {
        logic signed [COORD_BITS-1:0] c;
        logic [SLOPE_W-1:0]           s;
    } brk_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        brk_t             wdata;
        logic [IDX_W-1:0] raddr;
    } ram_req_t;

    // heap order on (coordinate, slope) pairs; max order for the left heap
    function automatic logic precedes(brk_t a, brk_t b, logic ismax);
        logic r;
        if (ismax)
            r = (a.c > b.c) || ((a.c == b.c) && (a.s > b.s));
        else
            r = (a.c < b.c) || ((a.c == b.c) && (a.s < b.s));
        return r;
    endfunction

endpackage

[design/stc_ram.sv]
module stc_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 56
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[design/stc_ctrl.sv]
module stc_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [2:0]                   opcode,
    input  logic signed [31:0]           coord_a,
    input  logic signed [31:0]           coord_b,
    input  logic [15:0]                  slope,
    input  logic signed [31:0]           const_value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [1:0]                   status,
    output logic signed [63:0]           min_value,
    output logic signed [39:0]           left_argmin,
    output logic signed [39:0]           right_argmin,
    output stc_pkg::ram_req_t            ram_l,
    output stc_pkg::ram_req_t            ram_r,
    input  stc_pkg::brk_t                rd_l,
    input  stc_pkg::brk_t                rd_r
);
    import stc_pkg::*;

    state_t                        state_reg, state_next;
    state_t                        ret_reg, ret_next;
    state_t                        mret_reg, mret_next;
    logic [2:0]                    op_reg, op_next;
    logic signed [31:0]            ca_reg, ca_next;
    logic signed [31:0]            cb_reg, cb_next;
    logic [SLOPE_W-1:0]            bl_reg, bl_next;
    logic [SLOPE_W-1:0]            t_reg, t_next;
    logic signed [31:0]            k_reg, k_next;
    logic [MIN_W-1:0]              min_reg, min_next;
    logic [CNT_W-1:0]              lcnt_reg, lcnt_next;
    logic [CNT_W-1:0]              rcnt_reg, rcnt_next;
    logic signed [COORD_BITS-1:0]  lsh_reg, lsh_next;
    logic signed [COORD_BITS-1:0]  rsh_reg, rsh_next;
    brk_t                          topl_reg, topl_next;
    brk_t                          topr_reg, topr_next;
    logic                          hsel_reg, hsel_next;
    brk_t                          e_reg, e_next;
    brk_t                          last_reg, last_next;
    brk_t                          ck_reg, ck_next;
    logic [IDX_W-1:0]              i_reg, i_next;
    logic [IDX_W-1:0]              kidx_reg, kidx_next;
    logic signed [COORD_BITS-1:0]  x0_reg, x0_next;
    logic signed [COORD_BITS:0]    ma_reg, ma_next;
    logic [SLOPE_W-1:0]            mb_reg, mb_next;
    logic                          msub_reg, msub_next;
    logic [MIN_W-1:0]              prod_reg, prod_next;
    status_t                       st_reg, st_next;
    logic                          ov_reg, ov_next;
    logic [1:0]                    ost_reg, ost_next;
    logic [MIN_W-1:0]              omin_reg, omin_next;
    logic signed [ARG_W-1:0]       oargl_reg, oargl_next;
    logic signed [ARG_W-1:0]       oargr_reg, oargr_next;

    // shared read address and write port, write enable per heap
    logic                          we;
    logic [IDX_W-1:0]              waddr;
    brk_t                          wdata;
    logic [IDX_W-1:0]              raddr;
    brk_t                          rd;

    logic signed [COORD_BITS-1:0]  x;
    logic                          nsel;
    logic [CNT_W-1:0]              cnt_n;
    logic [CNT_W-1:0]              cnt_h;
    logic signed [COORD_BITS-1:0]  sh_n;
    logic signed [COORD_BITS-1:0]  sh_f;
    brk_t                          top_n;
    logic signed [COORD_BITS-1:0]  arg_n;
    logic signed [COORD_BITS-1:0]  arg_l;
    logic signed [COORD_BITS-1:0]  arg_r;
    logic signed [COORD_BITS+16:0] prod_w;
    logic [IDX_W+1:0]              kk;
    logic [IDX_W+1:0]              k1;
    logic [IDX_W+1:0]              n_ext;

    assign rd = hsel_reg ? rd_r : rd_l;

    assign ram_l = '{we: we && !hsel_reg, waddr: waddr, wdata: wdata, raddr: raddr};
    assign ram_r = '{we: we && hsel_reg, waddr: waddr, wdata: wdata, raddr: raddr};

    // operand views of the current item: near heap is the one on the hinge side
    assign x      = COORD_BITS'(ca_reg);
    assign nsel   = (op_reg == OP_ADD_DEC);
    assign cnt_n  = nsel ? rcnt_reg : lcnt_reg;
    assign cnt_h  = hsel_reg ? rcnt_reg : lcnt_reg;
    assign sh_n   = nsel ? rsh_reg : lsh_reg;
    assign sh_f   = nsel ? lsh_reg : rsh_reg;
    assign top_n  = nsel ? topr_reg : topl_reg;
    assign arg_n  = top_n.c + sh_n;
    assign arg_l  = (lcnt_reg == '0) ? COORD_LO : topl_reg.c + lsh_reg;
    assign arg_r  = (rcnt_reg == '0) ? COORD_HI : topr_reg.c + rsh_reg;
    assign prod_w = ma_reg * $signed({1'b0, mb_reg});
    assign kk     = {1'b0, i_reg, 1'b1};
    assign k1     = (IDX_W+2)'(kidx_reg) + 1'b1;
    assign n_ext  = (IDX_W+2)'(cnt_h);

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = ov_reg;
    assign status       = ost_reg;
    assign min_value    = omin_reg;
    assign left_argmin  = oargl_reg;
    assign right_argmin = oargr_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            lcnt_reg  <= '0;
            rcnt_reg  <= '0;
            lsh_reg   <= '0;
            rsh_reg   <= '0;
            min_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            lcnt_reg  <= lcnt_next;
            rcnt_reg  <= rcnt_next;
            lsh_reg   <= lsh_next;
            rsh_reg   <= rsh_next;
            min_reg   <= min_next;
            ov_reg    <= ov_next;
        end
    end

    // working payload
    always_ff @(posedge clk)
    begin
        ret_reg   <= ret_next;
        mret_reg  <= mret_next;
        op_reg    <= op_next;
        ca_reg    <= ca_next;
        cb_reg    <= cb_next;
        bl_reg    <= bl_next;
        t_reg     <= t_next;
        k_reg     <= k_next;
        topl_reg  <= topl_next;
        topr_reg  <= topr_next;
        hsel_reg  <= hsel_next;
        e_reg     <= e_next;
        last_reg  <= last_next;
        ck_reg    <= ck_next;
        i_reg     <= i_next;
        kidx_reg  <= kidx_next;
        x0_reg    <= x0_next;
        ma_reg    <= ma_next;
        mb_reg    <= mb_next;
        msub_reg  <= msub_next;
        prod_reg  <= prod_next;
        st_reg    <= st_next;
        ost_reg   <= ost_next;
        omin_reg  <= omin_next;
        oargl_reg <= oargl_next;
        oargr_reg <= oargr_next;
    end

    // sequencer: item dispatch, hinge merge loop and heap sift engine
    always_comb
    begin
        logic   push_go;
        logic   push_sel;
        brk_t   push_e;
        state_t push_ret;
        logic   pop_go;

        push_go  = 1'b0;
        push_sel = 1'b0;
        push_e   = '0;
        push_ret = S_DONE;
        pop_go   = 1'b0;

        state_next = state_reg;
        ret_next   = ret_reg;
        mret_next  = mret_reg;
        op_next    = op_reg;
        ca_next    = ca_reg;
        cb_next    = cb_reg;
        bl_next    = bl_reg;
        t_next     = t_reg;
        k_next     = k_reg;
        min_next   = min_reg;
        lcnt_next  = lcnt_reg;
        rcnt_next  = rcnt_reg;
        lsh_next   = lsh_reg;
        rsh_next   = rsh_reg;
        topl_next  = topl_reg;
        topr_next  = topr_reg;
        hsel_next  = hsel_reg;
        e_next     = e_reg;
        last_next  = last_reg;
        ck_next    = ck_reg;
        i_next     = i_reg;
        kidx_next  = kidx_reg;
        x0_next    = x0_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        msub_next  = msub_reg;
        prod_next  = prod_reg;
        st_next    = st_reg;
        ost_next   = ost_reg;
        omin_next  = omin_reg;
        oargl_next = oargl_reg;
        oargr_next = oargr_reg;

        we    = 1'b0;
        waddr = '0;
        wdata = '0;
        raddr = '0;

        // result register drains independently of the sequencer
        ov_next = ov_reg && out_stall;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = opcode;
                    ca_next    = coord_a;
                    cb_next    = coord_b;
                    bl_next    = slope;
                    k_next     = const_value;
                    st_next    = ST_OK;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_DONE;
                case (op_reg)
                    OP_ADD_CONST:
                    begin
                        min_next = min_reg + MIN_W'(k_reg);
                    end
                    OP_ADD_DEC, OP_ADD_INC:
                    begin
                        if ((lcnt_reg > CNT_LIMIT) || (rcnt_reg > CNT_LIMIT))
                        begin
                            st_next = ST_FULL;
                        end
                        else if ((cnt_n == '0) || (nsel ? (x <= arg_n) : (x >= arg_n)))
                        begin
                            push_go  = 1'b1;
                            push_sel = !nsel;
                            push_e   = '{c: x - sh_f, s: bl_reg};
                            push_ret = S_DONE;
                        end
                        else
                        begin
                            x0_next    = arg_n;
                            ma_next    = nsel ? (COORD_BITS+1)'(x) - (COORD_BITS+1)'(arg_n)
                                              : (COORD_BITS+1)'(arg_n) - (COORD_BITS+1)'(x);
                            mb_next    = bl_reg;
                            msub_next  = 1'b0;
                            mret_next  = S_PUSH_NEAR;
                            state_next = S_MUL;
                        end
                    end
                    OP_SHIFT:
                    begin
                        lsh_next = lsh_reg - COORD_BITS'(ca_reg);
                        rsh_next = rsh_reg - COORD_BITS'(ca_reg);
                    end
                    OP_PREFIX_MIN:
                    begin
                        rcnt_next = '0;
                    end
                    OP_SUFFIX_MIN:
                    begin
                        lcnt_next = '0;
                    end
                    OP_RANGE_MIN:
                    begin
                        // net effect: left offset moves by xr, right offset by xl
                        if (ca_reg > cb_reg)
                        begin
                            st_next = ST_RANGE;
                        end
                        else
                        begin
                            lsh_next = lsh_reg - COORD_BITS'(cb_reg);
                            rsh_next = rsh_reg - COORD_BITS'(ca_reg);
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            // slope times distance, registered before it reaches the minimum
            S_MUL:
            begin
                prod_next  = MIN_W'(prod_w);
                state_next = S_ACC;
            end

            S_ACC:
            begin
                min_next   = msub_reg ? min_reg - prod_reg : min_reg + prod_reg;
                state_next = mret_reg;
            end

            S_PUSH_NEAR:
            begin
                push_go  = 1'b1;
                push_sel = nsel;
                push_e   = '{c: x - sh_n, s: bl_reg};
                push_ret = S_LOOP;
            end

            // rebalance: move slope across the minimum one breakpoint at a time
            S_LOOP:
            begin
                if ((bl_reg != '0) && (cnt_n != '0))
                begin
                    t_next = top_n.s;
                    pop_go = 1'b1;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_AFTERPOP:
            begin
                if (t_reg >= bl_reg)
                begin
                    push_go  = 1'b1;
                    push_sel = !nsel;
                    push_e   = '{c: x0_reg - sh_f, s: bl_reg};
                    push_ret = (t_reg > bl_reg) ? S_POST : S_DONE;
                end
                else if (cnt_n == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    bl_next    = bl_reg - t_reg;
                    x0_next    = arg_n;
                    ma_next    = nsel ? (COORD_BITS+1)'(arg_n) - (COORD_BITS+1)'(x0_reg)
                                      : (COORD_BITS+1)'(x0_reg) - (COORD_BITS+1)'(arg_n);
                    mb_next    = bl_reg - t_reg;
                    msub_next  = 1'b1;
                    mret_next  = S_LOOP;
                    state_next = S_MUL;
                end
            end

            S_POST:
            begin
                push_go  = 1'b1;
                push_sel = nsel;
                push_e   = '{c: x0_reg - sh_n, s: t_reg - bl_reg};
                push_ret = S_DONE;
            end

            // sift up: read parent, move it down while the new item wins
            S_PU_CHK:
            begin
                if (i_reg == '0)
                begin
                    state_next = S_PU_WR;
                end
                else
                begin
                    raddr      = (i_reg - 1'b1) >> 1;
                    kidx_next  = (i_reg - 1'b1) >> 1;
                    state_next = S_PU_CMP;
                end
            end

            S_PU_CMP:
            begin
                if (precedes(e_reg, rd, !hsel_reg))
                begin
                    we         = 1'b1;
                    waddr      = i_reg;
                    wdata      = rd;
                    i_next     = kidx_reg;
                    state_next = S_PU_CHK;
                end
                else
                begin
                    state_next = S_PU_WR;
                end
            end

            S_PU_WR:
            begin
                we         = 1'b1;
                waddr      = i_reg;
                wdata      = e_reg;
                state_next = ret_reg;
            end

            // sift down of the former last entry from the root
            S_PO_LAST:
            begin
                last_next  = rd;
                i_next     = '0;
                state_next = S_PO_CHK;
            end

            S_PO_CHK:
            begin
                if (kk >= n_ext)
                begin
                    state_next = S_PO_WR;
                end
                else
                begin
                    raddr      = kk[IDX_W-1:0];
                    kidx_next  = kk[IDX_W-1:0];
                    state_next = S_PO_K1;
                end
            end

            S_PO_K1:
            begin
                ck_next = rd;
                if (k1 < n_ext)
                begin
                    raddr      = k1[IDX_W-1:0];
                    state_next = S_PO_K2;
                end
                else
                begin
                    state_next = S_PO_CMP;
                end
            end

            S_PO_K2:
            begin
                if (precedes(rd, ck_reg, !hsel_reg))
                begin
                    ck_next   = rd;
                    kidx_next = k1[IDX_W-1:0];
                end
                state_next = S_PO_CMP;
            end

            S_PO_CMP:
            begin
                if (precedes(ck_reg, last_reg, !hsel_reg))
                begin
                    we         = 1'b1;
                    waddr      = i_reg;
                    wdata      = ck_reg;
                    i_next     = kidx_reg;
                    state_next = S_PO_CHK;
                end
                else
                begin
                    state_next = S_PO_WR;
                end
            end

            S_PO_WR:
            begin
                if (cnt_h != '0)
                begin
                    we    = 1'b1;
                    waddr = i_reg;
                    wdata = last_reg;
                end
                state_next = ret_reg;
            end

            // hand the result over once the output register is free
            S_DONE:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next    = 1'b1;
                    ost_next   = st_reg;
                    omin_next  = min_reg;
                    oargl_next = ARG_W'(arg_l);
                    oargr_next = ARG_W'(arg_r);
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // launch a push: new entry goes to the first free slot
        if (push_go)
        begin
            hsel_next  = push_sel;
            e_next     = push_e;
            ret_next   = push_ret;
            state_next = S_PU_CHK;
            if (push_sel)
            begin
                i_next    = rcnt_reg[IDX_W-1:0];
                rcnt_next = rcnt_reg + 1'b1;
            end
            else
            begin
                i_next    = lcnt_reg[IDX_W-1:0];
                lcnt_next = lcnt_reg + 1'b1;
            end
        end

        // launch a pop of the near heap: fetch its last entry
        if (pop_go)
        begin
            hsel_next  = nsel;
            ret_next   = S_AFTERPOP;
            state_next = S_PO_LAST;
            raddr      = IDX_W'(cnt_n - 1'b1);
            if (nsel)
            begin
                rcnt_next = rcnt_reg - 1'b1;
            end
            else
            begin
                lcnt_next = lcnt_reg - 1'b1;
            end
        end

        // shadow copy of each heap root
        if (we && (waddr == '0))
        begin
            if (hsel_reg)
            begin
                topr_next = wdata;
            end
            else
            begin
                topl_next = wdata;
            end
        end
    end

endmodule

[design/slope_trick_convex_function.sv]
// Convex piecewise-linear function in slope-trick form: a 64-bit minimum, two
// breakpoint heaps (left max-heap, right min-heap) of HEAP_DEPTH entries each in
// single-port-read RAMs, and a lazy offset per heap. One item in, one result out.
// Add const, shift, prefix/suffix/range min and rejected items pass from the
// execute state straight to the done state. A hinge walks the tree one level
// at a time for each push and each pop (one RAM read per child on a pop) and
// registers each slope product before it reaches the minimum, so its time
// grows with the heap depth and with each breakpoint popped across the
// minimum. The root of each heap is mirrored in a register, so the arg-min
// bounds come without a memory read. An item may be accepted while the previous
// result still waits on the output.
module slope_trick_convex_function (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         opcode,
    input  logic signed [31:0] coord_a,
    input  logic signed [31:0] coord_b,
    input  logic [15:0]        slope,
    input  logic signed [31:0] const_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic signed [63:0] min_value,
    output logic signed [39:0] left_argmin,
    output logic signed [39:0] right_argmin
);
    import stc_pkg::*;

    ram_req_t ram_l;
    ram_req_t ram_r;
    brk_t     rd_l;
    brk_t     rd_r;

    // left breakpoint heap
    stc_ram #(
        .DEPTH (HEAP_DEPTH),
        .WIDTH ($bits(brk_t))
    ) u_left_ram (
        .clk   (clk),
        .we    (ram_l.we),
        .waddr (ram_l.waddr),
        .wdata (ram_l.wdata),
        .raddr (ram_l.raddr),
        .rdata (rd_l)
    );

    // right breakpoint heap
    stc_ram #(
        .DEPTH (HEAP_DEPTH),
        .WIDTH ($bits(brk_t))
    ) u_right_ram (
        .clk   (clk),
        .we    (ram_r.we),
        .waddr (ram_r.waddr),
        .wdata (ram_r.wdata),
        .raddr (ram_r.raddr),
        .rdata (rd_r)
    );

    // sequencer and scalar state
    stc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .coord_a      (coord_a),
        .coord_b      (coord_b),
        .slope        (slope),
        .const_value  (const_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .min_value    (min_value),
        .left_argmin  (left_argmin),
        .right_argmin (right_argmin),
        .ram_l        (ram_l),
        .ram_r        (ram_r),
        .rd_l         (rd_l),
        .rd_r         (rd_r)
    );

endmodule

[sim/slope_trick_convex_function_checker.sv]
module slope_trick_convex_function_checker
    import stc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [2:0]         opcode,
    input  logic signed [31:0] coord_a,
    input  logic signed [31:0] coord_b,
    input  logic [15:0]        slope,
    input  logic signed [31:0] const_value,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [1:0]         status,
    input  logic signed [63:0] min_value,
    input  logic signed [39:0] left_argmin,
    input  logic signed [39:0] right_argmin,
    output int                 fail_count,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]         st;
        logic signed [63:0] minv;
        logic signed [39:0] larg;
        logic signed [39:0] rarg;
    } summary_t;

    typedef struct {
        longint c;
        int     s;
    } bp_t;

    // model state
    bp_t     lh[HEAP_DEPTH];
    bp_t     rh[HEAP_DEPTH];
    int      lcnt;
    int      rcnt;
    longint  lofs;
    longint  rofs;
    longint  acc;
    summary_t pend_q[$];

    // sign-extend the low coordinate bits
    function automatic longint wrap_coord(longint v);
        logic [COORD_BITS-1:0] t;
        t = v[COORD_BITS-1:0];
        return longint'(signed'(t));
    endfunction

    function automatic bit prior(bp_t a, bp_t b, bit ismax);
        if (ismax)
            return a.c > b.c || (a.c == b.c && a.s > b.s);
        return a.c < b.c || (a.c == b.c && a.s < b.s);
    endfunction

    task automatic heap_push(bit left, longint c, int s);
        bp_t e;
        int i;
        int p;
        e.c = c;
        e.s = s & 16'hffff;
        if (left)
        begin
            if (lcnt >= HEAP_DEPTH) return;
            i = lcnt;
            lcnt++;
            while (i > 0)
            begin
                p = (i - 1) / 2;
                if (!prior(e, lh[p], 1)) break;
                lh[i] = lh[p];
                i = p;
            end
            lh[i] = e;
        end
        else
        begin
            if (rcnt >= HEAP_DEPTH) return;
            i = rcnt;
            rcnt++;
            while (i > 0)
            begin
                p = (i - 1) / 2;
                if (!prior(e, rh[p], 0)) break;
                rh[i] = rh[p];
                i = p;
            end
            rh[i] = e;
        end
    endtask

    task automatic heap_pop(bit left);
        bp_t last;
        int i;
        int k;
        i = 0;
        if (left)
        begin
            if (lcnt == 0) return;
            lcnt--;
            last = lh[lcnt];
            forever
            begin
                k = 2 * i + 1;
                if (k >= lcnt) break;
                if (k + 1 < lcnt && prior(lh[k + 1], lh[k], 1)) k++;
                if (!prior(lh[k], last, 1)) break;
                lh[i] = lh[k];
                i = k;
            end
            if (lcnt > 0) lh[i] = last;
        end
        else
        begin
            if (rcnt == 0) return;
            rcnt--;
            last = rh[rcnt];
            forever
            begin
                k = 2 * i + 1;
                if (k >= rcnt) break;
                if (k + 1 < rcnt && prior(rh[k + 1], rh[k], 0)) k++;
                if (!prior(rh[k], last, 0)) break;
                rh[i] = rh[k];
                i = k;
            end
            if (rcnt > 0) rh[i] = last;
        end
    endtask

    function automatic longint left_bound();
        if (lcnt == 0) return longint'(COORD_LO);
        return wrap_coord(lh[0].c + lofs);
    endfunction

    function automatic longint right_bound();
        if (rcnt == 0) return longint'(COORD_HI);
        return wrap_coord(rh[0].c + rofs);
    endfunction

    task automatic move_origin(longint c);
        lofs = wrap_coord(lofs - c);
        rofs = wrap_coord(rofs - c);
    endtask

    // hinge sloping down to the left of x, merged across the minimum
    task automatic add_down(longint x, int beta);
        longint x0;
        longint nx;
        int b;
        int t;
        b = beta;
        if (rcnt == 0 || x <= right_bound())
        begin
            heap_push(1, wrap_coord(x - lofs), beta);
            return;
        end
        x0 = right_bound();
        acc += (x - x0) * longint'(beta);
        heap_push(0, wrap_coord(x - rofs), beta);
        while (b > 0 && rcnt > 0)
        begin
            t = rh[0].s;
            heap_pop(0);
            if (t >= b)
            begin
                heap_push(1, wrap_coord(x0 - lofs), b);
                if (t > b) heap_push(0, wrap_coord(x0 - rofs), t - b);
                b = 0;
            end
            else
            begin
                b -= t;
                if (rcnt == 0) break;
                nx = right_bound();
                acc -= longint'(b) * (nx - x0);
                x0 = nx;
            end
        end
    endtask

    // hinge sloping up to the right of x
    task automatic add_up(longint x, int beta);
        longint x0;
        longint nx;
        int b;
        int t;
        b = beta;
        if (lcnt == 0 || x >= left_bound())
        begin
            heap_push(0, wrap_coord(x - rofs), beta);
            return;
        end
        x0 = left_bound();
        acc += (x0 - x) * longint'(beta);
        heap_push(1, wrap_coord(x - lofs), beta);
        while (b > 0 && lcnt > 0)
        begin
            t = lh[0].s;
            heap_pop(1);
            if (t >= b)
            begin
                heap_push(0, wrap_coord(x0 - rofs), b);
                if (t > b) heap_push(1, wrap_coord(x0 - lofs), t - b);
                b = 0;
            end
            else
            begin
                b -= t;
                if (lcnt == 0) break;
                nx = left_bound();
                acc -= longint'(b) * (x0 - nx);
                x0 = nx;
            end
        end
    endtask

    task automatic apply_item(logic [2:0] op, longint a, longint b, int beta, longint k);
        summary_t r;
        r.st = ST_OK;
        case (op)
            OP_ADD_CONST: acc += k;
            OP_ADD_DEC, OP_ADD_INC:
            begin
                if (HEAP_DEPTH - lcnt < 2 || HEAP_DEPTH - rcnt < 2)
                    r.st = ST_FULL;
                else if (op == OP_ADD_DEC)
                    add_down(a, beta);
                else
                    add_up(a, beta);
            end
            OP_SHIFT: move_origin(a);
            OP_PREFIX_MIN: rcnt = 0;
            OP_SUFFIX_MIN: lcnt = 0;
            OP_RANGE_MIN:
            begin
                if (a > b)
                    r.st = ST_RANGE;
                else
                begin
                    if (a > 0)
                    begin
                        move_origin(a);
                        b -= a;
                        a = 0;
                    end
                    if (b < 0)
                    begin
                        move_origin(b);
                        a -= b;
                        b = 0;
                    end
                    lofs = wrap_coord(lofs - b);
                    rofs = wrap_coord(rofs - a);
                end
            end
            default: ;
        endcase
        r.minv = acc;
        r.larg = 40'(left_bound());
        r.rarg = 40'(right_bound());
        pend_q.push_back(r);
    endtask

    // predict on input items, compare on results
    always @(posedge clk or negedge rst_n)
    begin
        summary_t e;
        if (!rst_n)
        begin
            lcnt = 0;
            rcnt = 0;
            lofs = 0;
            rofs = 0;
            acc = 0;
            pend_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pend_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("result with nothing expected: st=%0d min=%0d",
                                 status, min_value);
                end
                else
                begin
                    e = pend_q.pop_front();
                    if (e.st !== status || e.minv !== min_value ||
                        e.larg !== left_argmin || e.rarg !== right_argmin)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"mismatch: exp st=%0d min=%0d l=%0d r=%0d, ",
                                      "got st=%0d min=%0d l=%0d r=%0d"},
                                     e.st, e.minv, e.larg, e.rarg,
                                     status, min_value, left_argmin, right_argmin);
                    end
                end
            end
            if (in_valid && !in_stall)
                apply_item(opcode, longint'(coord_a), longint'(coord_b),
                           int'(slope), longint'(const_value));
        end
        pending = pend_q.size();
    end
endmodule

[sim/slope_trick_convex_function_tb.sv]
module slope_trick_convex_function_tb;
    import stc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 200000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [2:0]         opcode;
    logic signed [31:0] coord_a;
    logic signed [31:0] coord_b;
    logic [15:0]        slope;
    logic signed [31:0] const_value;
    logic               out_valid;
    logic               out_stall;
    logic [1:0]         status;
    logic signed [63:0] min_value;
    logic signed [39:0] left_argmin;
    logic signed [39:0] right_argmin;
    int                 fail_count;
    int                 pending;
    int                 idle_cycles;

    slope_trick_convex_function DUT (.*);

    slope_trick_convex_function_checker u_checker (.*);

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // receiver stall pattern, with quiet and heavy stretches
    initial
    begin
        int mode;
        out_stall = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 2);
            repeat ($urandom_range(20, 200))
            begin
                @(posedge clk);
                if (mode == 0)
                    out_stall <= 1'b0;
                else if (mode == 1)
                    out_stall <= ($urandom_range(0, 3) == 0);
                else
                    out_stall <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    // watchdog on cycles with no accepted item on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("** slope_trick_convex_function: FAILED **");
            $finish;
        end
    end

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom();
            default: return 32'($signed($urandom_range(0, 200)) - 100);
        endcase
    endfunction

    // one item, held until accepted
    task automatic send_item(logic [2:0] op, logic [31:0] a, logic [31:0] b,
                             logic [15:0] s, logic [31:0] k);
        opcode      <= op;
        coord_a     <= a;
        coord_b     <= b;
        slope       <= s;
        const_value <= k;
        in_valid    <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic drop_valid();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_random();
        logic [2:0] op;
        logic [31:0] a;
        logic [31:0] b;
        logic [15:0] s;
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) op = ($urandom_range(0, 1) != 0) ? OP_ADD_DEC : OP_ADD_INC;
        else if (r < 65) op = OP_ADD_CONST;
        else if (r < 75) op = OP_SHIFT;
        else if (r < 80) op = OP_PREFIX_MIN;
        else if (r < 85) op = OP_SUFFIX_MIN;
        else if (r < 97) op = OP_RANGE_MIN;
        else op = OP_RESERVED;
        a = pick_coord();
        b = ($urandom_range(0, 4) == 0) ? pick_coord() : a + $urandom_range(0, 50);
        case ($urandom_range(0, 3))
            0: s = 16'($urandom());
            1: s = 16'hffff;
            default: s = 16'($urandom_range(0, 8));
        endcase
        send_item(op, a, b, s, $urandom());
    endtask

    initial
    begin
        int sent;
        int burst;
        in_valid = 1'b0;
        opcode = OP_ADD_CONST;
        coord_a = '0;
        coord_b = '0;
        slope = '0;
        const_value = '0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, every operation, special cases
        send_item(OP_ADD_CONST, 0, 0, 0, 32'h7fff_ffff);
        send_item(OP_ADD_CONST, 0, 0, 0, 32'h8000_0000);
        send_item(OP_ADD_DEC, 32'h8000_0000, 0, 16'hffff, 0);
        send_item(OP_ADD_INC, 32'h7fff_ffff, 0, 16'hffff, 0);
        send_item(OP_ADD_DEC, 10, 0, 3, 0);
        send_item(OP_ADD_INC, -10, 0, 5, 0);
        send_item(OP_ADD_DEC, 10, 0, 0, 0);
        send_item(OP_ADD_INC, 10, 0, 0, 0);
        send_item(OP_ADD_DEC, 50, 0, 2, 0);
        send_item(OP_ADD_INC, -50, 0, 20, 0);
        send_item(OP_SHIFT, 32'h7fff_ffff, 0, 0, 0);
        send_item(OP_SHIFT, 32'h8000_0000, 0, 0, 0);
        send_item(OP_RANGE_MIN, 5, -5, 0, 0);
        send_item(OP_RANGE_MIN, -3, 7, 0, 0);
        send_item(OP_RANGE_MIN, 4, 9, 0, 0);
        send_item(OP_RANGE_MIN, -9, -4, 0, 0);
        send_item(OP_RANGE_MIN, 32'h8000_0000, 32'h7fff_ffff, 0, 0);
        send_item(OP_RESERVED, 32'hffff_ffff, 32'hffff_ffff, 16'hffff, 32'hffff_ffff);
        send_item(OP_PREFIX_MIN, 0, 0, 0, 0);
        send_item(OP_SUFFIX_MIN, 0, 0, 0, 0);
        send_item(OP_ADD_INC, 0, 0, 1, 0);
        send_item(OP_ADD_DEC, 0, 0, 1, 0);
        drop_valid();

        // pause until every result is back
        while (pending != 0) @(posedge clk);

        // empty both heaps, then fill the left one up to the full-heap rejection
        send_item(OP_PREFIX_MIN, 0, 0, 0, 0);
        send_item(OP_SUFFIX_MIN, 0, 0, 0, 0);
        for (int i = 0; i < HEAP_DEPTH + 2; i++)
            send_item(OP_ADD_DEC, 32'(i), 0, 1, 0);
        send_item(OP_PREFIX_MIN, 0, 0, 0, 0);
        send_item(OP_SUFFIX_MIN, 0, 0, 0, 0);

        // random bursts with gaps
        sent = 0;
        while (sent < 150)
        begin
            burst = $urandom_range(1, 30);
            for (int i = 0; i < burst; i++)
            begin
                send_random();
                sent++;
            end
            if ($urandom_range(0, 1) != 0)
            begin
                drop_valid();
                repeat ($urandom_range(0, 40)) @(posedge clk);
            end
        end
        drop_valid();

        while (pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("** slope_trick_convex_function: PASSED **");
        else
            $display("** slope_trick_convex_function: FAILED **");
        $finish;
    end
endmodule
